@@ src/dqb_pkg.sv @@
package dqb_pkg;

    localparam int DEF_MAX_LABEL = 32;

    localparam logic [7:0]  DOT_CHAR = 8'h2E;
    localparam logic [15:0] QUERY_ID = 16'd12345;
    localparam logic [15:0] RD_FLAG  = 16'h0100;
    localparam logic [15:0] CLASS_IN = 16'h0001;

    localparam int HDR_LEN  = 12;
    localparam int TAIL_LEN = 5;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RECURSION  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_TYPE = 1'b1;

    // byte source select
    localparam logic [1:0] SRC_HDR  = 2'd0;
    localparam logic [1:0] SRC_LEN  = 2'd1;
    localparam logic [1:0] SRC_DATA = 2'd2;
    localparam logic [1:0] SRC_TAIL = 2'd3;

    typedef struct packed {
        logic       accept;     // input transfer this cycle
        logic       emit;       // load output register this cycle
        logic [1:0] src;        // byte source
        logic       idx_clr;    // restart byte index
        logic       hdr_set;    // header done
        logic       label_clr;  // label flushed
        logic       msg_clr;    // message done
    } t_cmd;

    typedef struct packed {
        logic in_flush;   // incoming char is a dot or carries name_end
        logic in_end;
        logic hdr_sent;
        logic lat_flush;
        logic lat_end;
        logic cnt_zero;
        logic idx_last;
        logic out_free;
    } t_stat;

    function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic rd);
        logic [15:0] flags;
        logic [7:0]  b;
        flags = rd ? RD_FLAG : 16'h0000;
        case (idx)
            4'd0:    b = QUERY_ID[15:8];
            4'd1:    b = QUERY_ID[7:0];
            4'd2:    b = flags[15:8];
            4'd3:    b = flags[7:0];
            4'd5:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] tail_byte(input logic [2:0] idx, input logic [15:0] qt);
        logic [7:0] b;
        case (idx)
            3'd1:    b = qt[15:8];
            3'd2:    b = qt[7:0];
            3'd3:    b = CLASS_IN[15:8];
            3'd4:    b = CLASS_IN[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ src/dqb_if.sv @@
interface dqb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_char;
    logic       name_end;
    modport source (output valid, output name_char, output name_end, input ready);
    modport sink   (input valid, input name_char, input name_end, output ready);
endinterface

interface dqb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       msg_last;
    logic       label_overflow;
    modport source (output valid, output msg_byte, output msg_last, output label_overflow,
                    input ready);
    modport sink   (input valid, input msg_byte, input msg_last, input label_overflow,
                    output ready);
endinterface

interface dqb_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dqb_pkg::CFG_IDX_W-1:0]    index;
    logic [dqb_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/dqb_ctrl.sv @@
module dqb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dqb_pkg::t_stat i_stat,
    output dqb_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HDR  = 3'd1;
    localparam logic [2:0] S_LEN  = 3'd2;
    localparam logic [2:0] S_DATA = 3'd3;
    localparam logic [2:0] S_TAIL = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.accept    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.emit      = (r_state != S_IDLE) && i_stat.out_free;
        case (r_state)
            S_IDLE: begin
                o_cmd.src = dqb_pkg::SRC_HDR;
                if (o_cmd.accept) begin
                    if (!i_stat.hdr_sent) begin
                        n_state = S_HDR;
                    end else if (i_stat.in_flush) begin
                        n_state = S_LEN;
                    end
                end
            end
            S_HDR: begin
                o_cmd.src = dqb_pkg::SRC_HDR;
                if (o_cmd.emit && i_stat.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    o_cmd.hdr_set = 1'b1;
                    n_state = i_stat.lat_flush ? S_LEN : S_IDLE;
                end
            end
            S_LEN: begin
                o_cmd.src = dqb_pkg::SRC_LEN;
                if (o_cmd.emit) begin
                    o_cmd.idx_clr = 1'b1;
                    if (i_stat.cnt_zero) begin
                        o_cmd.label_clr = 1'b1;
                        n_state = i_stat.lat_end ? S_TAIL : S_IDLE;
                    end else begin
                        n_state = S_DATA;
                    end
                end
            end
            S_DATA: begin
                o_cmd.src = dqb_pkg::SRC_DATA;
                if (o_cmd.emit && i_stat.idx_last) begin
                    o_cmd.idx_clr   = 1'b1;
                    o_cmd.label_clr = 1'b1;
                    n_state = i_stat.lat_end ? S_TAIL : S_IDLE;
                end
            end
            S_TAIL: begin
                o_cmd.src = dqb_pkg::SRC_TAIL;
                if (o_cmd.emit && i_stat.idx_last) begin
                    o_cmd.idx_clr = 1'b1;
                    o_cmd.msg_clr = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/dqb_dp.sv @@
module dqb_dp #(
    parameter int MAX_LABEL = dqb_pkg::DEF_MAX_LABEL
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dqb_in_if.sink         i_in,
    dqb_out_if.source      o_out,
    dqb_cfg_if.sink        i_cfg,
    input  dqb_pkg::t_cmd  i_cmd,
    output dqb_pkg::t_stat o_stat
);

    localparam int CW = $clog2(MAX_LABEL + 1);
    localparam int IW = (CW > 4) ? CW : 4;
    localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

    logic [7:0]  r_mem [MAX_LABEL];
    logic [7:0]  r_rd_data;

    logic [CW-1:0] r_count;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] n_idx;
    logic          r_ovf;
    logic          r_hdr_sent;
    logic          r_lat_flush;
    logic          r_lat_end;

    logic          r_rd;
    logic [15:0]   r_qtype;

    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_last;
    logic          r_out_ovf;

    logic          in_dot;
    logic          room;
    logic [7:0]    byte_sel;
    logic          last_sel;
    logic          ovf_sel;

    assign in_dot = (i_in.name_char == dqb_pkg::DOT_CHAR);
    assign room   = (r_count < CW'(MAX_LABEL));

    // config registers
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= 1'b1;
            r_qtype <= 16'd1;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                dqb_pkg::REG_RECURSION:  r_rd    <= i_cfg.data[0];
                dqb_pkg::REG_QUERY_TYPE: r_qtype <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // label store, read registered one index ahead
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.emit) begin
            n_idx = r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !in_dot && room) begin
            r_mem[r_count[AW-1:0]] <= i_in.name_char;
        end
        r_rd_data <= r_mem[n_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_hdr_sent  <= 1'b0;
            r_lat_flush <= 1'b0;
            r_lat_end   <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (i_cmd.accept) begin
                r_lat_flush <= in_dot || i_in.name_end;
                r_lat_end   <= i_in.name_end;
                if (!in_dot) begin
                    if (room) begin
                        r_count <= r_count + CW'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
            end
            if (i_cmd.hdr_set) begin
                r_hdr_sent <= 1'b1;
            end
            if (i_cmd.label_clr || i_cmd.msg_clr) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_cmd.msg_clr) begin
                r_hdr_sent <= 1'b0;
            end
        end
    end

    // byte mux
    always_comb begin
        byte_sel = 8'h00;
        last_sel = 1'b0;
        ovf_sel  = 1'b0;
        case (i_cmd.src)
            dqb_pkg::SRC_HDR:  byte_sel = dqb_pkg::hdr_byte(r_idx[3:0], r_rd);
            dqb_pkg::SRC_LEN: begin
                byte_sel = 8'(r_count);
                ovf_sel  = r_ovf;
            end
            dqb_pkg::SRC_DATA: begin
                byte_sel = r_rd_data;
                ovf_sel  = r_ovf;
            end
            dqb_pkg::SRC_TAIL: begin
                byte_sel = dqb_pkg::tail_byte(r_idx[2:0], r_qtype);
                last_sel = (r_idx == IW'(dqb_pkg::TAIL_LEN - 1));
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= byte_sel;
            r_out_last <= last_sel;
            r_out_ovf  <= ovf_sel;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.msg_byte       = r_out_byte;
    assign o_out.msg_last       = r_out_last;
    assign o_out.label_overflow = r_out_ovf;

    // status
    always_comb begin
        o_stat           = '0;
        o_stat.in_flush  = in_dot || i_in.name_end;
        o_stat.in_end    = i_in.name_end;
        o_stat.hdr_sent  = r_hdr_sent;
        o_stat.lat_flush = r_lat_flush;
        o_stat.lat_end   = r_lat_end;
        o_stat.cnt_zero  = (r_count == '0);
        o_stat.out_free  = !r_out_valid || o_out.ready;
        case (i_cmd.src)
            dqb_pkg::SRC_HDR:  o_stat.idx_last = (r_idx == IW'(dqb_pkg::HDR_LEN - 1));
            dqb_pkg::SRC_LEN:  o_stat.idx_last = 1'b1;
            dqb_pkg::SRC_DATA: o_stat.idx_last = (r_idx == IW'(r_count) - IW'(1));
            dqb_pkg::SRC_TAIL: o_stat.idx_last = (r_idx == IW'(dqb_pkg::TAIL_LEN - 1));
            default:           o_stat.idx_last = 1'b1;
        endcase
    end

endmodule

@@ src/dns_query_builder.sv @@
// An ordinary character, other than the first of a message, is buffered while the
//   builder is idle and gives no bytes; after any other item is taken the controller
//   leaves idle and loads each byte into the single output register once it is free
//   (header 12, length + label bytes, tail 5); no character is taken meanwhile.
// Reset (i_rst_n, synchronous, active low): no message open, label empty,
//   recursion_desired = 1, query_type = 1. The label store itself is not cleared.
module dns_query_builder #(
    parameter int MAX_LABEL = dqb_pkg::DEF_MAX_LABEL
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dqb_in_if.sink     i_in,
    dqb_out_if.source  o_out,
    dqb_cfg_if.sink    i_cfg
);

    // Controller decides the byte sequence (header, length, label, tail) and
    // steps the datapath one byte per cycle whenever the output register is
    // free or being drained by this cycle's transfer.
    dqb_pkg::t_cmd  cmd;
    dqb_pkg::t_stat stat;

    dqb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath: label memory (registered read, prefetching the next index),
    // label count and overflow flag, config registers and output register.
    dqb_dp #(
        .MAX_LABEL (MAX_LABEL)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule
